FILE: design/rpts_pkg.sv
// shared types, widths, constants and tanh table for the recurrent perceptron step unit
`default_nettype none

package rpts_pkg;

	localparam int NUM_INPUTS       = 6;
	localparam int NUM_OUTPUTS      = 2;
	localparam int TANH_TABLE_DEPTH = 256;
	localparam int TANH_IDX_W       = $clog2(TANH_TABLE_DEPTH);
	// |sum| in Q4.28 maps to index |sum| * DEPTH / 2^30
	localparam int TANH_SHIFT       = 30 - TANH_IDX_W;

	localparam int DIST_W     = 14;
	localparam int ANGLE_W    = 16;
	localparam int DRIVE_W    = 16;
	localparam int WEIGHT_W   = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int LUT_W      = 15;

	// input order of the weight registers
	localparam logic [CFG_IDX_W-1:0] IDX_SHEEP_DIST    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_PREV_FORWARD  = 3'd5;

	// distance / 2000 in Q2.14 == (d * 2048 + 125) / 250, by reciprocal
	localparam int                 DIST_SAT_LIMIT = 4000;
	localparam logic [11:0]        DIST_ROUND     = 12'd125;
	localparam logic [23:0]        DIST_RECIP     = 24'd8589935;
	localparam int                 DIST_RECIP_SH  = 31;
	localparam logic [15:0]        DIST_SAT_VALUE = 16'd32767;

	localparam logic [63:0] Q32_ONE = 64'h0000_0001_0000_0000;

	// series argument 8/DEPTH in Q32
	localparam logic [63:0] TANH_STEP_ARG = (64'd8 << 32) / 64'(TANH_TABLE_DEPTH);

	typedef logic [TANH_TABLE_DEPTH-1:0][LUT_W-1:0] tanh_lut_t;
	typedef logic [NUM_INPUTS-1:0][CFG_DATA_W-1:0]  weight_bank_t;

	// restoring long division, used at elaboration time only
	function automatic logic [63:0] udiv64(
		input logic [63:0] numer,
		input logic [63:0] denom
	);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], numer[i]};
			if (rem >= {1'b0, denom}) begin
				rem    = rem - {1'b0, denom};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// elaboration-time table: entry k ~ tanh(4k/DEPTH) in Q1.14
	function automatic tanh_lut_t build_tanh_lut();
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] num;
		logic [63:0] den;
		tanh_lut_t   lut;
		r    = TANH_STEP_ARG;
		term = Q32_ONE;
		pos  = Q32_ONE;
		neg  = '0;
		e    = Q32_ONE;
		for (int n = 1; n <= 12; n++) begin
			term = udiv64((term * r) >> 32, 64'(n));
			if ((n & 1) == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		b = (pos > neg) ? (pos - neg) : 64'd0;
		for (int k = 0; k < TANH_TABLE_DEPTH; k++) begin
			if (k > 0) begin
				e = (e * b) >> 32;
			end
			num    = (Q32_ONE - e) * 64'd16384;
			den    = Q32_ONE + e;
			lut[k] = LUT_W'(udiv64(64'd2 * num + den, 64'd2 * den));
		end
		return lut;
	endfunction

	localparam tanh_lut_t TANH_LUT = build_tanh_lut();

endpackage

`default_nettype wire

FILE: design/rpts_if.sv
// channel interfaces: sensor sample in, drive result out
`default_nettype none

interface rpts_in_if;
	logic                                     valid;
	logic                                     ready;
	logic        [rpts_pkg::DIST_W-1:0]       sheep_distance;
	logic signed [rpts_pkg::ANGLE_W-1:0]      sheep_bearing;
	logic        [rpts_pkg::DIST_W-1:0]       goal_distance;
	logic signed [rpts_pkg::ANGLE_W-1:0]      goal_bearing;

	modport source (
		output valid, sheep_distance, sheep_bearing, goal_distance, goal_bearing,
		input  ready
	);
	modport sink (
		input  valid, sheep_distance, sheep_bearing, goal_distance, goal_bearing,
		output ready
	);
endinterface

interface rpts_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [rpts_pkg::DRIVE_W-1:0]      turn_drive;
	logic signed [rpts_pkg::DRIVE_W-1:0]      forward_drive;

	modport source (
		output valid, turn_drive, forward_drive,
		input  ready
	);
	modport sink (
		input  valid, turn_drive, forward_drive,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/recurrent_perceptron_tanh_step_unit.sv
// recurrent perceptron step: six-input, two-output dot products with tanh lookup
// latency: a sample accepted into stage 1 passes through stages 2, 3 and 4 to result.valid
// throughput: one transaction per cycle while result is not stalled; the feedback loop closes in stage 4
// (two feedback products, final add and table lookup feed the result register)
// reset: weights and previous outputs clear to zero, all pipeline valids drop
// a stalled result holds stage 4 while earlier empty stages keep accepting
`default_nettype none

module recurrent_perceptron_tanh_step_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [rpts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rpts_pkg::CFG_DATA_W-1:0]     cfg_data,
	rpts_in_if.sink                                  sample,
	rpts_out_if.source                               result
);

	// weight registers: bits 15:0 to turn, bits 31:16 to forward
	rpts_pkg::weight_bank_t weight_q;

	// pipeline valids and per-stage ready chain
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// stage 1: raw sample
	logic        [rpts_pkg::DIST_W-1:0]  sheep_dist_s1;
	logic signed [rpts_pkg::ANGLE_W-1:0] sheep_bear_s1;
	logic        [rpts_pkg::DIST_W-1:0]  goal_dist_s1;
	logic signed [rpts_pkg::ANGLE_W-1:0] goal_bear_s1;

	// stage 2: scaled Q2.14 inputs
	logic signed [15:0] x_c  [4];
	logic signed [15:0] x_s2 [4];

	// stage 3: partial sums over the four sensor inputs, Q4.28
	logic signed [33:0] psum_c  [rpts_pkg::NUM_OUTPUTS];
	logic signed [33:0] psum_s3 [rpts_pkg::NUM_OUTPUTS];

	// stage 4: full sums, activation, result / feedback state
	logic signed [35:0]                      sum_c  [rpts_pkg::NUM_OUTPUTS];
	logic signed [rpts_pkg::DRIVE_W-1:0]     res_c  [rpts_pkg::NUM_OUTPUTS];
	logic signed [rpts_pkg::DRIVE_W-1:0]     res_s4 [rpts_pkg::NUM_OUTPUTS];

	// ---------------------------------------------------------------------
	// handshake: each stage advances when empty or when the next one moves
	// ---------------------------------------------------------------------
	assign rdy_s4 = !valid_s4 || result.ready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign sample.ready        = rdy_s1;
	assign result.valid        = valid_s4;
	assign result.turn_drive   = res_s4[0];
	assign result.forward_drive = res_s4[1];

	// ---------------------------------------------------------------------
	// configuration writes; indexes past the last weight pair are dropped
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (cfg_wr_en && (cfg_index <= rpts_pkg::IDX_PREV_FORWARD)) begin
			weight_q[cfg_index] <= cfg_data;
		end
	end

	// ---------------------------------------------------------------------
	// valid pipeline
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= sample.valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 1: capture the sample transaction
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy_s1 && sample.valid) begin
			sheep_dist_s1 <= sample.sheep_distance;
			sheep_bear_s1 <= sample.sheep_bearing;
			goal_dist_s1  <= sample.goal_distance;
			goal_bear_s1  <= sample.goal_bearing;
		end
	end

	// ---------------------------------------------------------------------
	// stage 2: distance / 2000 rounded half up with saturation,
	// angle Q1.15 -> Q2.14 rounded half up
	// ---------------------------------------------------------------------
	function automatic logic signed [15:0] scale_distance(
		input logic [rpts_pkg::DIST_W-1:0] d
	);
		logic [22:0] numer;
		logic [46:0] prod;
		numer = {d[10:0], 11'd0} + {11'd0, rpts_pkg::DIST_ROUND};
		numer = numer + {d[11], 22'd0};
		prod  = 47'(numer) * 47'(rpts_pkg::DIST_RECIP);
		if (32'(d) >= 32'(rpts_pkg::DIST_SAT_LIMIT)) begin
			return $signed(rpts_pkg::DIST_SAT_VALUE);
		end
		return $signed(prod[rpts_pkg::DIST_RECIP_SH +: 16]);
	endfunction

	function automatic logic signed [15:0] scale_angle(
		input logic signed [rpts_pkg::ANGLE_W-1:0] a
	);
		logic signed [16:0] a1;
		a1 = 17'(a) + 17'sd1;
		return a1[16:1];
	endfunction

	always_comb begin
		x_c[0] = scale_distance(sheep_dist_s1);
		x_c[1] = scale_angle(sheep_bear_s1);
		x_c[2] = scale_distance(goal_dist_s1);
		x_c[3] = scale_angle(goal_bear_s1);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			x_s2 <= x_c;
		end
	end

	// ---------------------------------------------------------------------
	// stage 3: eight sensor products, summed per output
	// ---------------------------------------------------------------------
	always_comb begin
		for (int o = 0; o < rpts_pkg::NUM_OUTPUTS; o++) begin
			psum_c[o] = '0;
			for (int j = 0; j < 4; j++) begin
				psum_c[o] = psum_c[o]
					+ 34'($signed(weight_q[j][rpts_pkg::WEIGHT_W*o +: rpts_pkg::WEIGHT_W])
					* x_s2[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			psum_s3 <= psum_c;
		end
	end

	// ---------------------------------------------------------------------
	// stage 4: add feedback products of the last result, then tanh lookup
	// res_s4 is both the output register and the recurrent state
	// ---------------------------------------------------------------------
	always_comb begin
		logic        [35:0]                     mag;
		logic                                   neg;
		logic        [rpts_pkg::TANH_IDX_W-1:0] idx;
		logic        [rpts_pkg::LUT_W-1:0]      t;
		for (int o = 0; o < rpts_pkg::NUM_OUTPUTS; o++) begin
			sum_c[o] = 36'(psum_s3[o])
				+ 36'($signed(weight_q[4][rpts_pkg::WEIGHT_W*o +: rpts_pkg::WEIGHT_W])
				* res_s4[0])
				+ 36'($signed(weight_q[5][rpts_pkg::WEIGHT_W*o +: rpts_pkg::WEIGHT_W])
				* res_s4[1]);
			neg = sum_c[o][35];
			mag = neg ? 36'(-sum_c[o]) : 36'(sum_c[o]);
			// magnitude of 4.0 or more pins to the last entry
			if (|mag[35:30]) begin
				idx = '1;
			end else begin
				idx = mag[rpts_pkg::TANH_SHIFT +: rpts_pkg::TANH_IDX_W];
			end
			t        = rpts_pkg::TANH_LUT[idx];
			res_c[o] = neg ? -$signed(16'(t)) : $signed(16'(t));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s4[0] <= '0;
			res_s4[1] <= '0;
		end else if (rdy_s4 && valid_s3) begin
			res_s4 <= res_c;
		end
	end

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	logic load_s4;
	assign load_s4 = rdy_s4 && valid_s3;

	// table output stays within [-1, 1] in Q1.14
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.turn_drive <= 16'sd16384)
			&& (result.turn_drive >= -16'sd16384)
			&& (result.forward_drive <= 16'sd16384)
			&& (result.forward_drive >= -16'sd16384))
		else $error("drive out of range");

	// a zero turn sum yields a zero turn drive
	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s4 && (sum_c[0] == 36'sd0)) |=> (result.turn_drive == 16'sd0))
		else $error("zero sum gave nonzero turn drive");

	// a positive forward sum yields a non-negative forward drive
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s4 && (sum_c[1] > 36'sd0)) |=> (result.forward_drive >= 16'sd0))
		else $error("forward drive sign mismatch");

	// writes past the last weight pair leave the weights alone
	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && (cfg_index > rpts_pkg::IDX_PREV_FORWARD)) |=> $stable(weight_q))
		else $error("out-of-range config write changed weights");

	// recurrent state only changes when stage 4 loads
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s4 |=> $stable(result.turn_drive) && $stable(result.forward_drive))
		else $error("feedback state changed without a load");

endmodule

`default_nettype wire
